>>> hw/rtl/lz77d_pkg.sv
// Package for the LZ77 block decompressor: sizes, status and config codes, shared structs.
// No dependencies.
`default_nettype none
package lz77d_pkg;
  localparam int InAw = 16;
  localparam int HistAw = 16;
  localparam int LenW = 17;
  localparam int CntW = 24;
  localparam int RunW = 32;
  localparam logic [LenW-1:0] InputDepth = 17'h10000;
  localparam logic [RunW-1:0] MinMatchLen = 32'd4;

  localparam logic [1:0] StByte = 2'd0;
  localparam logic [1:0] StDone = 2'd1;
  localparam logic [1:0] StCorrupt = 2'd2;
  localparam logic [1:0] StOverflow = 2'd3;

  localparam logic CfgInputLength = 1'b0;
  localparam logic CfgOutputCapacity = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // write a compressed byte
    logic rd_in;     // start a read of the compressed store
    logic rd_hist;   // start a read of the history ring
    logic exec;      // decode one step on read data
  } lz77d_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_match;  // next step copies from history
    logic emit;      // exec produced a result
  } lz77d_sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/lz77d_ctrl.sv
// Controller for the LZ77 block decompressor: request handshake and step sequencing.
// Depends on lz77d_pkg.
`default_nettype none
module lz77d_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  input  wire logic               req_type_i,
  output logic                    req_ready_o,
  input  wire logic               res_busy_i,
  input  wire lz77d_pkg::lz77d_sts_t sts_i,
  output lz77d_pkg::lz77d_cmd_t   cmd_o
);
  import lz77d_pkg::*;

  localparam logic [0:0] SIdle = 1'b0;
  localparam logic [0:0] SExec = 1'b1;

  logic [0:0] state_q, state_d;
  logic take;

  // Accept a request only when idle and no result waits.
  assign req_ready_o = (state_q == SIdle) && !res_busy_i;
  assign take = req_valid_i && req_ready_o;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (take) begin
          if (!req_type_i) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.rd_in = 1'b1;
            cmd_o.rd_hist = sts_i.is_match;
            state_d = SExec;
          end
        end
      end
      SExec: begin
        cmd_o.exec = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // A step never starts while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_in |-> !res_busy_i)
    else $error("step started with result pending");
  // An execute always follows a read in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_in |=> cmd_o.exec)
    else $error("read without execute");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> !req_ready_o)
    else $error("ready during execute");
  // The datapath produces a result only in an execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.emit |-> cmd_o.exec)
    else $error("result outside execute");
endmodule
`default_nettype wire

>>> hw/rtl/lz77d_dp.sv
// Datapath for the LZ77 block decompressor: stores, decode registers, result register.
// Depends on lz77d_pkg.
`default_nettype none
module lz77d_dp (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [7:0]               data_byte_i,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_idx_i,
  input  wire logic [lz77d_pkg::CntW-1:0] cfg_data_i,
  input  wire lz77d_pkg::lz77d_cmd_t    cmd_i,
  output lz77d_pkg::lz77d_sts_t         sts_o,
  output logic                          res_valid_o,
  input  wire logic                     res_ready_i,
  output logic [1:0]                    status_o,
  output logic [7:0]                    out_byte_o,
  output logic [lz77d_pkg::CntW-1:0]    produced_count_o
);
  import lz77d_pkg::*;

  localparam logic [3:0] PhToken = 4'd0;
  localparam logic [3:0] PhLext = 4'd1;
  localparam logic [3:0] PhMext = 4'd2;
  localparam logic [3:0] PhOffLo = 4'd3;
  localparam logic [3:0] PhOffHi = 4'd4;
  localparam logic [3:0] PhLit = 4'd5;
  localparam logic [3:0] PhMatch = 4'd6;
  localparam logic [3:0] PhDone = 4'd7;
  localparam logic [3:0] PhCorrupt = 4'd8;
  localparam logic [3:0] PhOverflow = 4'd9;

  logic [7:0] in_mem [2**InAw];
  logic [7:0] hist_mem [2**HistAw];
  logic [7:0] in_rd_q, hist_rd_q;

  logic [LenW-1:0] in_len_q, load_cnt_q, rpos_q, rpos_d;
  logic [CntW-1:0] cap_q, ocnt_q, ocnt_d;
  logic [3:0] ph_q, ph_d;
  logic [RunW-1:0] lit_q, lit_d, mrem_q, mrem_d;
  logic [15:0] off_q, off_d;
  logic [3:0] mnib_q, mnib_d;

  logic hist_we;
  logic [7:0] hist_wdata;
  logic emit;
  logic [1:0] st_d;
  logic [7:0] ob_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_len_q <= '0;
      cap_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgInputLength: in_len_q <= cfg_data_i[LenW-1:0];
        CfgOutputCapacity: cap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Compressed store: written by loads, read at the decode position.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_cnt_q < InputDepth) begin
      in_mem[load_cnt_q[InAw-1:0]] <= data_byte_i;
    end
    if (cmd_i.rd_in) begin
      in_rd_q <= in_mem[rpos_q[InAw-1:0]];
    end
  end

  // History ring: written with every output byte, read for match copies.
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[ocnt_q[HistAw-1:0]] <= hist_wdata;
    end
    if (cmd_i.rd_hist) begin
      hist_rd_q <= hist_mem[ocnt_q[HistAw-1:0] - off_q];
    end
  end

  assign sts_o.is_match = (ph_q == PhMatch);
  assign sts_o.emit = emit;

  logic [LenW-1:0] n;
  logic [LenW+1:0] rp_ext;
  logic [RunW+1:0] rp_lit;
  logic [RunW:0] oc_lit, oc_m;
  logic [RunW-1:0] lit_ext;

  assign n = (in_len_q > InputDepth) ? InputDepth : in_len_q;
  assign rp_ext = {2'b0, rpos_q} + (LenW+2)'(2);
  assign rp_lit = {{(RunW+2-LenW){1'b0}}, rpos_q} + {2'b0, lit_q};
  assign oc_lit = {{(RunW+1-CntW){1'b0}}, ocnt_q} + {1'b0, lit_q};
  assign oc_m = {{(RunW+1-CntW){1'b0}}, ocnt_q} + {1'b0, mrem_q};
  assign lit_ext = lit_q + {24'd0, in_rd_q};

  // Decide on a match once the literal count is final.
  function automatic logic match_follows(input logic [3:0] nib, input logic [RunW-1:0] lit,
                                         input logic [LenW-1:0] rp, input logic [LenW-1:0] len);
    logic [RunW+1:0] s;
    begin
      s = {{(RunW+2-LenW){1'b0}}, rp} + {2'b0, lit} + (RunW+2)'(2);
      match_follows = (nib != 4'd0) || (s <= {{(RunW+2-LenW){1'b0}}, len});
    end
  endfunction

  // One decode step on the data read in the previous cycle.
  always_comb begin
    logic [RunW-1:0] lit_v;
    logic known;
    rpos_d = rpos_q; ocnt_d = ocnt_q; ph_d = ph_q; lit_d = lit_q; mrem_d = mrem_q;
    off_d = off_q; mnib_d = mnib_q;
    hist_we = 1'b0; hist_wdata = in_rd_q; emit = 1'b0; st_d = StByte; ob_d = 8'd0;
    lit_v = lit_q; known = 1'b0;
    if (cmd_i.exec) begin
      unique case (ph_q)
        PhToken: begin
          if (rpos_q >= n) begin
            ph_d = PhDone; emit = 1'b1; st_d = StDone;
          end else begin
            rpos_d = rpos_q + 1'b1;
            lit_v = {28'd0, in_rd_q[7:4]};
            lit_d = lit_v;
            mnib_d = in_rd_q[3:0];
            if (in_rd_q[7:4] == 4'hF) ph_d = PhLext;
            else known = 1'b1;
          end
        end
        PhLext: begin
          if (rpos_q >= n) begin
            ph_d = PhCorrupt; emit = 1'b1; st_d = StCorrupt;
          end else begin
            rpos_d = rpos_q + 1'b1;
            lit_v = lit_ext;
            lit_d = lit_v;
            known = (in_rd_q != 8'hFF);
          end
        end
        PhMext: begin
          if (rpos_q >= n) begin
            ph_d = PhCorrupt; emit = 1'b1; st_d = StCorrupt;
          end else begin
            rpos_d = rpos_q + 1'b1;
            mrem_d = mrem_q + {24'd0, in_rd_q};
            if (in_rd_q != 8'hFF) ph_d = PhOffLo;
          end
        end
        PhOffLo: begin
          if (rp_ext > {2'b0, n}) begin
            ph_d = PhCorrupt; emit = 1'b1; st_d = StCorrupt;
          end else begin
            rpos_d = rpos_q + 1'b1;
            off_d = {8'd0, in_rd_q};
            ph_d = PhOffHi;
          end
        end
        PhOffHi: begin
          if (rpos_q >= n) begin
            ph_d = PhCorrupt; emit = 1'b1; st_d = StCorrupt;
          end else begin
            rpos_d = rpos_q + 1'b1;
            off_d = {in_rd_q, off_q[7:0]};
            if ({in_rd_q, off_q[7:0]} == 16'd0) begin
              ph_d = PhCorrupt; emit = 1'b1; st_d = StCorrupt;
            end else begin
              ph_d = (lit_q != '0) ? PhLit : PhMatch;
            end
          end
        end
        PhLit: begin
          if (rp_lit > {{(RunW+2-LenW){1'b0}}, n}) begin
            ph_d = PhCorrupt; emit = 1'b1; st_d = StCorrupt;
          end else if (oc_lit > {{(RunW+1-CntW){1'b0}}, cap_q}) begin
            ph_d = PhOverflow; emit = 1'b1; st_d = StOverflow;
          end else begin
            rpos_d = rpos_q + 1'b1;
            hist_we = 1'b1; hist_wdata = in_rd_q;
            ocnt_d = ocnt_q + 1'b1;
            lit_d = lit_q - 1'b1;
            emit = 1'b1; ob_d = in_rd_q;
            if (lit_q == 32'd1) ph_d = (mrem_q != '0) ? PhMatch : PhToken;
          end
        end
        PhMatch: begin
          if ({8'd0, off_q} > ocnt_q) begin
            ph_d = PhCorrupt; emit = 1'b1; st_d = StCorrupt;
          end else if (oc_m > {{(RunW+1-CntW){1'b0}}, cap_q}) begin
            ph_d = PhOverflow; emit = 1'b1; st_d = StOverflow;
          end else begin
            hist_we = 1'b1; hist_wdata = hist_rd_q;
            ocnt_d = ocnt_q + 1'b1;
            mrem_d = mrem_q - 1'b1;
            emit = 1'b1; ob_d = hist_rd_q;
            if (mrem_q == 32'd1) ph_d = PhToken;
          end
        end
        PhDone: begin
          emit = 1'b1; st_d = StDone;
        end
        PhCorrupt: begin
          emit = 1'b1; st_d = StCorrupt;
        end
        default: begin
          ph_d = PhOverflow; emit = 1'b1; st_d = StOverflow;
        end
      endcase
      // Literal count is final: pick the next phase.
      if (known) begin
        if (match_follows(ph_q == PhToken ? in_rd_q[3:0] : mnib_q, lit_v, rpos_d, n)) begin
          mrem_d = MinMatchLen + {28'd0, (ph_q == PhToken ? in_rd_q[3:0] : mnib_q)};
          ph_d = ((ph_q == PhToken ? in_rd_q[3:0] : mnib_q) == 4'hF) ? PhMext : PhOffLo;
        end else begin
          mrem_d = '0;
          ph_d = (lit_v != '0) ? PhLit : PhToken;
        end
      end
    end
  end

  // Decode state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0; rpos_q <= '0; ocnt_q <= '0; ph_q <= PhToken;
      lit_q <= '0; mrem_q <= '0; off_q <= '0; mnib_q <= '0;
    end else begin
      if (cmd_i.load && load_cnt_q < InputDepth) load_cnt_q <= load_cnt_q + 1'b1;
      rpos_q <= rpos_d; ocnt_q <= ocnt_d; ph_q <= ph_d;
      lit_q <= lit_d; mrem_q <= mrem_d; off_q <= off_d; mnib_q <= mnib_d;
    end
  end

  // Result register; count includes the byte just emitted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else if (emit) begin
      res_valid_o <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_o <= st_d; out_byte_o <= ob_d; produced_count_o <= ocnt_d;
    end
  end

  // Terminal phases never leave except by reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PhDone || ph_q == PhCorrupt || ph_q == PhOverflow) |=> $stable(ph_q))
    else $error("left terminal phase");
  // The output count advances only on an emitted byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ocnt_d != ocnt_q) |-> (emit && st_d == StByte))
    else $error("count moved without byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_hist |-> ph_q == PhMatch)
    else $error("history read outside match");
endmodule
`default_nettype wire

>>> hw/rtl/lz77_block_decompressor.sv
// Top level of the LZ77 block decompressor: stream ports, controller and datapath.
// Depends on lz77d_pkg, lz77d_ctrl and lz77d_dp.
`default_nettype none
// Load a block one byte per request (req_type 0), set input_length,
// then send tick requests (req_type 1). Each tick does a registered read of the
// compressed store or history ring, then the decode step in the following cycle.
// A tick is accepted only once any earlier result has been taken, so no new
// tick starts while a result waits on the master stream, where results come out;
// done, corrupt and overflow repeat on later ticks.
module lz77_block_decompressor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  wire logic        s_axis_tuser,   // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // out_byte[7:0], produced_count[31:8]
  output logic [1:0]       m_axis_tuser,   // status[1:0]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [lz77d_pkg::CntW-1:0] cfg_data_i
);
  import lz77d_pkg::*;

  lz77d_cmd_t cmd;
  lz77d_sts_t sts;
  logic [1:0] status;
  logic [7:0] out_byte;
  logic [CntW-1:0] produced_count;

  assign cfg_ready_o = 1'b1;
  assign m_axis_tdata = {produced_count, out_byte};
  assign m_axis_tuser = status;

  lz77d_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i(s_axis_tvalid), .req_type_i(s_axis_tuser), .req_ready_o(s_axis_tready),
    .res_busy_i(m_axis_tvalid), .sts_i(sts), .cmd_o(cmd)
  );

  lz77d_dp u_dp (
    .clk_i, .rst_ni,
    .data_byte_i(s_axis_tdata),
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .cmd_i(cmd), .sts_o(sts),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .status_o(status), .out_byte_o(out_byte), .produced_count_o(produced_count)
  );
endmodule
`default_nettype wire
